FILE: sv/aabb_clip_space_cull_assert.svh
// Assertion macros used by the clip-space cull checker.
// Each macro expects clk to be visible where it is used, and all but ACULL_ASSERT_NEXT_ALWAYS expect rst_n.
`ifndef AABB_CLIP_SPACE_CULL_ASSERT_SVH
`define AABB_CLIP_SPACE_CULL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACULL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACULL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same as ACULL_ASSERT_NEXT, but also checked while reset is asserted.
`define ACULL_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/acull_pkg.sv
// Package for the clip-space box cull: widths, data types, register indexes and reset values.
// It has no dependencies and is used by every module of the block but the checker.
package acull_pkg;

  localparam int COORD_W   = 16;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 32;
  localparam int DOT_W     = 34;
  localparam int ROW_W     = 64;
  localparam int NAXIS     = 3;
  localparam int NROW      = 4;
  localparam int NCORNER   = 8;
  localparam int NPLANE    = 2 * NAXIS;
  localparam int CFG_IDX_W = 3;
  localparam int ONE_SHIFT = 8;
  localparam int W_ROW     = 3;
  localparam int W_COL     = 3;
  localparam int NSTAGE    = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DOT_W-1:0]   dot_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [NPLANE-1:0]         planes_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  localparam cfg_idx_t REG_ROW0 = 3'd0;
  localparam cfg_idx_t REG_ROW1 = 3'd1;
  localparam cfg_idx_t REG_ROW2 = 3'd2;
  localparam cfg_idx_t REG_ROW3 = 3'd3;

  localparam row_t ROW0_RST = 64'h0000_0000_0000_1000;
  localparam row_t ROW1_RST = 64'h0000_0000_1000_0000;
  localparam row_t ROW2_RST = 64'h0000_1000_0000_0000;
  localparam row_t ROW3_RST = 64'h1000_0000_0000_0000;

  function automatic elem_t get_elem(row_t row, int col);
    return row[ELEM_W*col +: ELEM_W];
  endfunction

endpackage

FILE: sv/acull_mul.sv
// Product stage: multiplies each x, y and z matrix element by the min and max coordinate of its column,
// and shifts the w column element up by ONE_SHIFT into a bias. Depends on acull_pkg.
module acull_mul (
  input  logic             clk,
  input  logic             en,
  input  acull_pkg::coord_t lo [acull_pkg::NAXIS],
  input  acull_pkg::coord_t hi [acull_pkg::NAXIS],
  input  acull_pkg::row_t   rows [acull_pkg::NROW],
  output acull_pkg::prod_t  prod_r [acull_pkg::NROW][acull_pkg::NAXIS][2],
  output acull_pkg::dot_t   bias_r [acull_pkg::NROW]
);

  acull_pkg::prod_t prod_nxt [acull_pkg::NROW][acull_pkg::NAXIS][2];
  acull_pkg::dot_t  bias_nxt [acull_pkg::NROW];

  always_comb begin
    for (int r = 0; r < acull_pkg::NROW; r++) begin
      for (int a = 0; a < acull_pkg::NAXIS; a++) begin
        prod_nxt[r][a][0] = acull_pkg::prod_t'(acull_pkg::get_elem(rows[r], a))
                            * acull_pkg::prod_t'(lo[a]);
        prod_nxt[r][a][1] = acull_pkg::prod_t'(acull_pkg::get_elem(rows[r], a))
                            * acull_pkg::prod_t'(hi[a]);
      end
      bias_nxt[r] = acull_pkg::dot_t'(acull_pkg::get_elem(rows[r], acull_pkg::W_COL))
                    <<< acull_pkg::ONE_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      bias_r <= bias_nxt;
    end
  end

endmodule

FILE: sv/acull_sum.sv
// Dot-product stage: adds the products chosen by each of the eight corners to the bias, per matrix row.
// Depends on acull_pkg.
module acull_sum (
  input  logic             clk,
  input  logic             en,
  input  acull_pkg::prod_t prod [acull_pkg::NROW][acull_pkg::NAXIS][2],
  input  acull_pkg::dot_t  bias [acull_pkg::NROW],
  output acull_pkg::dot_t  dot_r [acull_pkg::NCORNER][acull_pkg::NROW]
);

  acull_pkg::dot_t dot_nxt [acull_pkg::NCORNER][acull_pkg::NROW];

  always_comb begin
    for (int k = 0; k < acull_pkg::NCORNER; k++) begin
      for (int r = 0; r < acull_pkg::NROW; r++) begin
        dot_nxt[k][r] = bias[r]
                      + acull_pkg::dot_t'(prod[r][0][k[0]])
                      + acull_pkg::dot_t'(prod[r][1][k[1]])
                      + acull_pkg::dot_t'(prod[r][2][k[2]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r <= dot_nxt;
    end
  end

endmodule

FILE: sv/acull_cmp.sv
// Compare stage: tests every corner against plus and minus w and reduces over the corners.
// Depends on acull_pkg.
module acull_cmp (
  input  logic              clk,
  input  logic              en,
  input  acull_pkg::dot_t   dot [acull_pkg::NCORNER][acull_pkg::NROW],
  output acull_pkg::planes_t planes_r,
  output logic              inside_r
);

  logic [acull_pkg::NAXIS-1:0] gt_all;
  logic [acull_pkg::NAXIS-1:0] lt_all;
  acull_pkg::planes_t          planes_nxt;

  always_comb begin
    gt_all = '1;
    lt_all = '1;
    for (int k = 0; k < acull_pkg::NCORNER; k++) begin
      for (int a = 0; a < acull_pkg::NAXIS; a++) begin
        if (!(dot[k][a] > dot[k][acull_pkg::W_ROW])) begin
          gt_all[a] = 1'b0;
        end
        if (!(dot[k][a] < -dot[k][acull_pkg::W_ROW])) begin
          lt_all[a] = 1'b0;
        end
      end
    end
    planes_nxt = {lt_all, gt_all};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      planes_r <= planes_nxt;
      inside_r <= ~|planes_nxt;
    end
  end

endmodule

FILE: sv/aabb_clip_space_cull.sv
// Clip-space box cull top level: input register, product, dot-product and compare stages.
// Throughput is one box per cycle while the output is not stalled, set by the four-stage pipeline,
// and a stalled output only holds stages that are occupied.
// Synchronous active-low reset empties the pipeline and loads the identity matrix.
// Depends on acull_pkg, acull_mul, acull_sum and acull_cmp.
module aabb_clip_space_cull (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [15:0]           in_min_x,
  input  logic signed [15:0]           in_min_y,
  input  logic signed [15:0]           in_min_z,
  input  logic signed [15:0]           in_max_x,
  input  logic signed [15:0]           in_max_y,
  input  logic signed [15:0]           in_max_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_inside_res,
  output logic [5:0]                   out_outside_planes,
  input  logic                         cfg_wr_en,
  input  logic [acull_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                  cfg_wdata
);

  acull_pkg::row_t   rows_r [acull_pkg::NROW];
  acull_pkg::coord_t lo_r [acull_pkg::NAXIS];
  acull_pkg::coord_t hi_r [acull_pkg::NAXIS];
  acull_pkg::prod_t  prod [acull_pkg::NROW][acull_pkg::NAXIS][2];
  acull_pkg::dot_t   bias [acull_pkg::NROW];
  acull_pkg::dot_t   dot [acull_pkg::NCORNER][acull_pkg::NROW];
  acull_pkg::planes_t planes;
  logic              visible;

  logic [acull_pkg::NSTAGE-1:0] vld_r;
  logic [acull_pkg::NSTAGE-1:0] en;

  assign en[3] = !vld_r[3] || out_ready;
  assign en[2] = !vld_r[2] || en[3];
  assign en[1] = !vld_r[1] || en[2];
  assign en[0] = !vld_r[0] || en[1];

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
      if (en[3]) vld_r[3] <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0] <= acull_pkg::ROW0_RST;
      rows_r[1] <= acull_pkg::ROW1_RST;
      rows_r[2] <= acull_pkg::ROW2_RST;
      rows_r[3] <= acull_pkg::ROW3_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        acull_pkg::REG_ROW0: rows_r[0] <= cfg_wdata;
        acull_pkg::REG_ROW1: rows_r[1] <= cfg_wdata;
        acull_pkg::REG_ROW2: rows_r[2] <= cfg_wdata;
        acull_pkg::REG_ROW3: rows_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      lo_r[0] <= in_min_x;
      lo_r[1] <= in_min_y;
      lo_r[2] <= in_min_z;
      hi_r[0] <= in_max_x;
      hi_r[1] <= in_max_y;
      hi_r[2] <= in_max_z;
    end
  end

  acull_mul u_mul (
    .clk    (clk),
    .en     (en[1]),
    .lo     (lo_r),
    .hi     (hi_r),
    .rows   (rows_r),
    .prod_r (prod),
    .bias_r (bias)
  );

  acull_sum u_sum (
    .clk   (clk),
    .en    (en[2]),
    .prod  (prod),
    .bias  (bias),
    .dot_r (dot)
  );

  acull_cmp u_cmp (
    .clk      (clk),
    .en       (en[3]),
    .dot      (dot),
    .planes_r (planes),
    .inside_r (visible)
  );

  assign out_valid          = vld_r[3];
  assign out_inside_res     = visible;
  assign out_outside_planes = planes;

endmodule

FILE: sv/acull_checker.sv
// Port-level checker for the clip-space box cull, bound to the top level.
// Depends on aabb_clip_space_cull_assert.svh.
`include "aabb_clip_space_cull_assert.svh"

module acull_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_inside_res,
  input logic [5:0] out_outside_planes
);

  `ACULL_ASSERT_NOW(a_inside_matches_planes, out_valid, out_inside_res == (out_outside_planes == 6'd0), "inside flag disagrees with plane mask")
  `ACULL_ASSERT_NOW(a_ready_when_drained, out_ready || !out_valid, in_ready, "input stalled although the output can move")
  `ACULL_ASSERT_NEXT_ALWAYS(a_empty_after_reset, !rst_n, !out_valid, "result valid right after reset")
  `ACULL_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(out_outside_planes) && $stable(out_inside_res), "stalled result changed")

endmodule

bind aabb_clip_space_cull acull_checker u_acull_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for aabb_clip_space_cull: predicts the cull verdict of each box from a
// local copy of the matrix rows and checks every result transaction in order.
// Depends on acull_pkg and the aabb_clip_space_cull RTL.
module testbench;

  localparam acull_pkg::cfg_idx_t REG_SPARE_LO = 3'd4;
  localparam acull_pkg::cfg_idx_t REG_SPARE_HI = 3'd7;
  localparam longint ONE_W = longint'(1) << acull_pkg::ONE_SHIFT;

  typedef struct packed {
    acull_pkg::coord_t min_x;
    acull_pkg::coord_t min_y;
    acull_pkg::coord_t min_z;
    acull_pkg::coord_t max_x;
    acull_pkg::coord_t max_y;
    acull_pkg::coord_t max_z;
  } box_t;

  typedef struct packed {
    logic               visible;
    acull_pkg::planes_t planes;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  acull_pkg::coord_t   in_min_x = '0;
  acull_pkg::coord_t   in_min_y = '0;
  acull_pkg::coord_t   in_min_z = '0;
  acull_pkg::coord_t   in_max_x = '0;
  acull_pkg::coord_t   in_max_y = '0;
  acull_pkg::coord_t   in_max_z = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_inside_res;
  acull_pkg::planes_t  out_outside_planes;
  logic                cfg_wr_en = 1'b0;
  acull_pkg::cfg_idx_t cfg_index = '0;
  acull_pkg::row_t     cfg_wdata = '0;

  acull_pkg::row_t mat_rows [acull_pkg::NROW] = '{acull_pkg::ROW0_RST, acull_pkg::ROW1_RST,
                                                  acull_pkg::ROW2_RST, acull_pkg::ROW3_RST};
  verdict_t expected_verdicts [$];
  int       in_idle_pct = 0;
  int       out_idle_pct = 0;
  int       boxes_sent = 0;
  int       verdicts_checked = 0;
  int       matrices_loaded = 0;
  int       mismatches = 0;

  aabb_clip_space_cull u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_min_x           (in_min_x),
    .in_min_y           (in_min_y),
    .in_min_z           (in_min_z),
    .in_max_x           (in_max_x),
    .in_max_y           (in_max_y),
    .in_max_z           (in_max_z),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_inside_res     (out_inside_res),
    .out_outside_planes (out_outside_planes),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("aabb_clip_space_cull regression: fail");
    $finish;
  end

  function automatic longint row_dot(acull_pkg::row_t row, longint vx, longint vy, longint vz);
    longint           v [acull_pkg::NROW];
    longint           s;
    acull_pkg::elem_t e;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    v[3] = ONE_W;
    s = 0;
    for (int c = 0; c < acull_pkg::NROW; c++) begin
      e = row[c*acull_pkg::ELEM_W +: acull_pkg::ELEM_W];
      s += longint'(e) * v[c];
    end
    return s;
  endfunction

  function automatic verdict_t cull_predict(box_t b);
    longint                     lo [acull_pkg::NAXIS];
    longint                     hi [acull_pkg::NAXIS];
    longint                     w;
    longint                     p;
    longint                     vx;
    longint                     vy;
    longint                     vz;
    logic [acull_pkg::NAXIS-1:0] all_gt;
    logic [acull_pkg::NAXIS-1:0] all_lt;
    verdict_t                   r;
    lo[0] = b.min_x;
    lo[1] = b.min_y;
    lo[2] = b.min_z;
    hi[0] = b.max_x;
    hi[1] = b.max_y;
    hi[2] = b.max_z;
    all_gt = '1;
    all_lt = '1;
    for (int k = 0; k < acull_pkg::NCORNER; k++) begin
      vx = (k & 1) ? hi[0] : lo[0];
      vy = (k & 2) ? hi[1] : lo[1];
      vz = (k & 4) ? hi[2] : lo[2];
      w = row_dot(mat_rows[acull_pkg::W_ROW], vx, vy, vz);
      for (int a = 0; a < acull_pkg::NAXIS; a++) begin
        p = row_dot(mat_rows[a], vx, vy, vz);
        if (!(p > w)) all_gt[a] = 1'b0;
        if (!(p < -w)) all_lt[a] = 1'b0;
      end
    end
    r.planes = {all_lt, all_gt};
    r.visible = (r.planes == '0);
    return r;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: inside_res=%0b outside_planes=%0h",
               out_inside_res, out_outside_planes);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        verdicts_checked++;
        if (out_inside_res !== want.visible) begin
          $error("inside_res: expected %0b, actual %0b", want.visible, out_inside_res);
          mismatches++;
        end
        if (out_outside_planes !== want.planes) begin
          $error("outside_planes: expected %0h, actual %0h", want.planes, out_outside_planes);
          mismatches++;
        end
      end
    end
  end

  task automatic send_box(input box_t b);
    verdict_t want;
    want = cull_predict(b);
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_min_x <= b.min_x;
    in_min_y <= b.min_y;
    in_min_z <= b.min_z;
    in_max_x <= b.max_x;
    in_max_y <= b.max_y;
    in_max_z <= b.max_z;
    do @(posedge clk); while (!in_ready);
    expected_verdicts.push_back(want);
    boxes_sent++;
  endtask

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (acull_pkg::NSTAGE + 2) @(posedge clk);
  endtask

  task automatic cfg_write(input acull_pkg::cfg_idx_t idx, input acull_pkg::row_t data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      acull_pkg::REG_ROW0: mat_rows[0] = data;
      acull_pkg::REG_ROW1: mat_rows[1] = data;
      acull_pkg::REG_ROW2: mat_rows[2] = data;
      acull_pkg::REG_ROW3: mat_rows[3] = data;
      default: ;
    endcase
  endtask

  task automatic load_matrix(input acull_pkg::row_t r0, input acull_pkg::row_t r1,
                             input acull_pkg::row_t r2, input acull_pkg::row_t r3);
    settle_pipeline();
    cfg_write(acull_pkg::REG_ROW0, r0);
    cfg_write(acull_pkg::REG_ROW1, r1);
    cfg_write(acull_pkg::REG_ROW2, r2);
    cfg_write(acull_pkg::REG_ROW3, r3);
    matrices_loaded++;
  endtask

  function automatic acull_pkg::row_t pack_row(int e0, int e1, int e2, int e3);
    return {e3[15:0], e2[15:0], e1[15:0], e0[15:0]};
  endfunction

  function automatic int small_signed(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic box_t mk_box(int ax, int ay, int az, int bx, int by, int bz);
    box_t b;
    b.min_x = acull_pkg::coord_t'(ax);
    b.min_y = acull_pkg::coord_t'(ay);
    b.min_z = acull_pkg::coord_t'(az);
    b.max_x = acull_pkg::coord_t'(bx);
    b.max_y = acull_pkg::coord_t'(by);
    b.max_z = acull_pkg::coord_t'(bz);
    return b;
  endfunction

  function automatic box_t rand_box();
    int lo [acull_pkg::NAXIS];
    int hi [acull_pkg::NAXIS];
    int c;
    int h;
    int t;
    if ($urandom_range(3) == 0) return {$urandom, $urandom, $urandom};
    for (int a = 0; a < acull_pkg::NAXIS; a++) begin
      c = small_signed(2048);
      h = $urandom_range(512);
      lo[a] = c - h;
      hi[a] = c + h;
      if ($urandom_range(15) == 0) begin
        t = lo[a];
        lo[a] = hi[a];
        hi[a] = t;
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  task automatic load_random_matrix();
    case ($urandom_range(2))
      0: load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      1: load_matrix(pack_row($urandom_range(1024, 12288), small_signed(256),
                              small_signed(256), small_signed(4096)),
                     pack_row(small_signed(256), $urandom_range(1024, 12288),
                              small_signed(256), small_signed(4096)),
                     pack_row(small_signed(256), small_signed(256),
                              $urandom_range(1024, 12288), small_signed(4096)),
                     pack_row(small_signed(128), small_signed(128),
                              small_signed(128), 4096 + small_signed(1024)));
      default: load_matrix(pack_row($urandom_range(2048, 8192), 0, small_signed(512), 0),
                           pack_row(0, $urandom_range(2048, 8192), small_signed(512), 0),
                           pack_row(0, 0, -$urandom_range(2048, 6144), -$urandom_range(8192)),
                           pack_row(small_signed(64), small_signed(64), -4096,
                                    small_signed(2048)));
    endcase
  endtask

  // Boxes against the identity matrix: each plane alone, the three plus or the three minus planes
  // together, corners exactly on a plane, coordinate extremes and a min corner above the max corner.
  task automatic test_plane_cases();
    send_box(mk_box(-128, -128, -128, 128, 128, 128));
    send_box(mk_box(300, 0, 0, 400, 10, 10));
    send_box(mk_box(0, 300, 0, 10, 400, 10));
    send_box(mk_box(0, 0, 300, 10, 10, 400));
    send_box(mk_box(-400, 0, 0, -300, 10, 10));
    send_box(mk_box(0, -400, 0, 10, -300, 10));
    send_box(mk_box(0, 0, -400, 10, 10, -300));
    send_box(mk_box(300, 300, 300, 400, 400, 400));
    send_box(mk_box(-400, -400, -400, -300, -300, -300));
    send_box(mk_box(256, 0, 0, 512, 0, 0));
    send_box(mk_box(257, 0, 0, 512, 0, 0));
    send_box(mk_box(-512, -512, 0, -256, -257, 0));
    send_box(mk_box(0, 0, 256, 0, 0, 256));
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(400, 0, 0, 300, 0, 0));
    send_box(mk_box(300, 0, 0, -300, 0, 0));
    send_box(mk_box(32767, -32768, 32767, -32768, 32767, -32768));
  endtask

  task automatic run_extreme_boxes(input int n_random);
    send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
    repeat (n_random) send_box(rand_box());
  endtask

  task automatic test_matrix_extremes();
    load_matrix('0, '0, '0, '0);
    run_extreme_boxes(3);
    load_matrix({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
    run_extreme_boxes(3);
    load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    run_extreme_boxes(3);
    load_matrix('1, '1, '1, '1);
    run_extreme_boxes(3);
    load_matrix({4{16'h7fff}}, {4{16'h8000}}, {4{16'h7fff}}, {4{16'h8000}});
    run_extreme_boxes(3);
    load_matrix({4{16'h8000}}, {4{16'h7fff}}, {4{16'h8000}}, {4{16'h7fff}});
    run_extreme_boxes(3);
  endtask

  // Writes to unused indexes must leave the matrix untouched.
  task automatic test_spare_indexes();
    load_matrix(acull_pkg::ROW0_RST, acull_pkg::ROW1_RST, acull_pkg::ROW2_RST,
                acull_pkg::ROW3_RST);
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
      cfg_write(acull_pkg::cfg_idx_t'(i), '1);
    end
    send_box(mk_box(300, 0, 0, 400, 10, 10));
    send_box(mk_box(0, -400, 0, 10, -300, 10));
    send_box(mk_box(-128, -128, -128, 128, 128, 128));
    send_box(mk_box(0, 0, 257, 0, 0, 300));
  endtask

  task automatic test_random_traffic(input int n, input int src_pct, input int dst_pct);
    in_idle_pct = src_pct;
    out_idle_pct = dst_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) load_random_matrix();
      send_box(rand_box());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_plane_cases();
    test_matrix_extremes();
    test_spare_indexes();
    test_random_traffic(200, 16, 58);
    test_random_traffic(200, 58, 16);
    test_random_traffic(200, 0, 0);
    settle_pipeline();
    $display("Sent %0d boxes under %0d matrix loads and checked %0d verdicts,",
             boxes_sent, matrices_loaded, verdicts_checked);
    $display("with idle cycles on either side, on neither side and spare index writes.");
    if (mismatches == 0) begin
      $display("aabb_clip_space_cull regression: pass");
    end else begin
      $display("aabb_clip_space_cull regression: fail");
    end
    $finish;
  end

endmodule
